/* rtl/core/pfd_pkg.sv */
// ----------------------------------------------------------------------------
// pfd_pkg: shared types and constants of the packet FIFO
// Item and result layouts, command and status codes, and the internal
// operation format passed from the front end to the back end.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam logic [1:0] CMD_INIT   = 2'd0;
  localparam logic [1:0] CMD_HEADER = 2'd1;
  localparam logic [1:0] CMD_DATA   = 2'd2;
  localparam logic [1:0] CMD_POP    = 2'd3;

  localparam logic [15:0] DROP_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_LENGTH  = 3'd1,
    ST_QUEUE_FULL  = 3'd2,
    ST_QUEUE_EMPTY = 3'd3,
    ST_TOO_SMALL   = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] packet_length;
    logic [7:0] data_byte;
    logic [6:0] capacity;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [6:0]  popped_length;
    logic        last;
    logic [3:0]  stored_packets;
    logic [15:0] overflow_count;
  } result_t;

  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_HDR_OK  = 3'd1,
    OP_HDR_BAD = 3'd2,
    OP_DATA    = 3'd3,
    OP_POP     = 3'd4
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] length;
    logic [7:0] data_byte;
    logic [6:0] capacity;
  } op_item_t;

  typedef enum logic [2:0] {
    BK_IDLE   = 3'b001,
    BK_LEN    = 3'b010,
    BK_STREAM = 3'b100
  } bk_state_t;

endpackage

/* rtl/core/pfd_ram.sv */
// ----------------------------------------------------------------------------
// pfd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data. The read
// data holds while no read is issued.
// ----------------------------------------------------------------------------
module pfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/pfd_front.sv */
// ----------------------------------------------------------------------------
// pfd_front: command decode
// Turns an incoming beat into an internal operation and judges the
// announced length of a push header.
// ----------------------------------------------------------------------------
module pfd_front #(
  parameter int MAX_PACKET_BYTES = 64
) (
  input  pfd_pkg::in_item_t item,
  output pfd_pkg::op_item_t op_item
);

  always_comb begin
    op_item.length    = item.packet_length;
    op_item.data_byte = item.data_byte;
    op_item.capacity  = item.capacity;
    case (item.cmd)
      pfd_pkg::CMD_INIT: op_item.op = pfd_pkg::OP_INIT;
      pfd_pkg::CMD_HEADER: begin
        if (item.packet_length == 7'd0 ||
            item.packet_length > 7'(MAX_PACKET_BYTES)) begin
          op_item.op = pfd_pkg::OP_HDR_BAD;
        end else begin
          op_item.op = pfd_pkg::OP_HDR_OK;
        end
      end
      pfd_pkg::CMD_DATA: op_item.op = pfd_pkg::OP_DATA;
      pfd_pkg::CMD_POP:  op_item.op = pfd_pkg::OP_POP;
      default:           op_item.op = pfd_pkg::OP_INIT;
    endcase
  end

endmodule

/* rtl/core/pfd_queue.sv */
// ----------------------------------------------------------------------------
// pfd_queue: two-entry operation queue
// Decouples the front end from the back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module pfd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_stall,
  input  pfd_pkg::op_item_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output pfd_pkg::op_item_t pop_data
);

  pfd_pkg::op_item_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_stall = (cnt_r == 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/core/pfd_back.sv */
// ----------------------------------------------------------------------------
// pfd_back: queue state and packet store
// Executes operations against the packet ring: fills the tail slot, commits
// packets, counts drops and streams popped packets through the output
// register.
// ----------------------------------------------------------------------------
module pfd_back #(
  parameter int QUEUE_DEPTH      = 8,
  parameter int MAX_PACKET_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  pfd_pkg::op_item_t q_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pfd_pkg::result_t  out_data
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W  = $clog2(MAX_PACKET_BYTES + 1);
  localparam int BYTES  = QUEUE_DEPTH * MAX_PACKET_BYTES;
  localparam int ADDR_W = $clog2(BYTES);

  pfd_pkg::bk_state_t state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [15:0]       drop_r, drop_nxt;
  logic              push_open_r, push_open_nxt;
  logic [POS_W-1:0]  wpos_r, wpos_nxt;
  logic [POS_W-1:0]  exp_r, exp_nxt;
  logic [6:0]        cap_r, cap_nxt;
  logic [POS_W-1:0]  len_r, len_nxt;
  logic [POS_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0] baddr_r, baddr_nxt;
  logic              out_valid_r, out_valid_nxt;
  pfd_pkg::result_t  out_data_r, out_data_nxt;

  logic              space, emit;
  logic [CNT_W:0]    tail_sum;
  logic [IDX_W-1:0]  tail, head_wrap;
  logic [POS_W-1:0]  wpos_inc, idx_inc;

  logic              b_we, b_re;
  logic [ADDR_W-1:0] b_waddr, b_raddr;
  logic [7:0]        b_wdata, b_rdata;
  logic              l_we, l_re;
  logic [IDX_W-1:0]  l_waddr, l_raddr;
  logic [POS_W-1:0]  l_wdata, l_rdata;

  function automatic logic [ADDR_W-1:0] slot_base(input logic [IDX_W-1:0] s);
    return ADDR_W'(s) * ADDR_W'(MAX_PACKET_BYTES);
  endfunction

  pfd_ram #(.WIDTH(8), .DEPTH(BYTES)) u_bytes (
    .clk  (clk),
    .we   (b_we),
    .waddr(b_waddr),
    .wdata(b_wdata),
    .re   (b_re),
    .raddr(b_raddr),
    .rdata(b_rdata)
  );

  pfd_ram #(.WIDTH(POS_W), .DEPTH(QUEUE_DEPTH)) u_lengths (
    .clk  (clk),
    .we   (l_we),
    .waddr(l_waddr),
    .wdata(l_wdata),
    .re   (l_re),
    .raddr(l_raddr),
    .rdata(l_rdata)
  );

  // head + count stays below twice the depth, so one subtract wraps it.
  assign tail_sum  = (CNT_W+1)'(head_r) + (CNT_W+1)'(count_r);
  assign tail      = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                     IDX_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
  assign head_wrap = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
  assign wpos_inc  = wpos_r + POS_W'(1);
  assign idx_inc   = idx_r + POS_W'(1);
  assign space     = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    push_open_nxt = push_open_r;
    wpos_nxt      = wpos_r;
    exp_nxt       = exp_r;
    cap_nxt       = cap_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    baddr_nxt     = baddr_r;
    q_pop         = 1'b0;
    emit          = 1'b0;
    out_data_nxt  = '0;
    out_data_nxt.status = pfd_pkg::ST_OK;
    out_data_nxt.last   = 1'b1;
    b_we    = 1'b0;
    b_waddr = slot_base(tail) + ADDR_W'(wpos_r);
    b_wdata = q_data.data_byte;
    b_re    = 1'b0;
    b_raddr = baddr_r;
    l_we    = 1'b0;
    l_waddr = tail;
    l_wdata = exp_r;
    l_re    = 1'b0;
    l_raddr = head_r;

    case (state_r)
      pfd_pkg::BK_IDLE: begin
        if (q_valid && space) begin
          q_pop = 1'b1;
          case (q_data.op)
            pfd_pkg::OP_INIT: begin
              emit          = 1'b1;
              head_nxt      = '0;
              count_nxt     = '0;
              drop_nxt      = '0;
              push_open_nxt = 1'b0;
              wpos_nxt      = '0;
              exp_nxt       = '0;
            end
            pfd_pkg::OP_HDR_BAD: begin
              emit          = 1'b1;
              push_open_nxt = 1'b0;
              wpos_nxt      = '0;
              exp_nxt       = '0;
              out_data_nxt.status = pfd_pkg::ST_BAD_LENGTH;
            end
            pfd_pkg::OP_HDR_OK: begin
              emit     = 1'b1;
              wpos_nxt = '0;
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                push_open_nxt = 1'b0;
                exp_nxt       = '0;
                if (drop_r != pfd_pkg::DROP_MAX) begin
                  drop_nxt = drop_r + 16'd1;
                end
                out_data_nxt.status = pfd_pkg::ST_QUEUE_FULL;
              end else begin
                push_open_nxt = 1'b1;
                exp_nxt       = POS_W'(q_data.length);
              end
            end
            pfd_pkg::OP_DATA: begin
              // A data beat with no push open is dropped without a result.
              if (push_open_r) begin
                emit     = 1'b1;
                b_we     = 1'b1;
                wpos_nxt = wpos_inc;
                if (wpos_inc >= exp_r) begin
                  l_we          = 1'b1;
                  count_nxt     = count_r + CNT_W'(1);
                  push_open_nxt = 1'b0;
                  wpos_nxt      = '0;
                  exp_nxt       = '0;
                end
              end
            end
            pfd_pkg::OP_POP: begin
              if (count_r == '0) begin
                emit = 1'b1;
                out_data_nxt.status = pfd_pkg::ST_QUEUE_EMPTY;
              end else begin
                l_re      = 1'b1;
                cap_nxt   = q_data.capacity;
                state_nxt = pfd_pkg::BK_LEN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      pfd_pkg::BK_LEN: begin
        if (cap_r < 7'(l_rdata)) begin
          if (space) begin
            emit      = 1'b1;
            state_nxt = pfd_pkg::BK_IDLE;
            out_data_nxt.status = pfd_pkg::ST_TOO_SMALL;
          end
        end else begin
          b_re      = 1'b1;
          b_raddr   = slot_base(head_r);
          baddr_nxt = slot_base(head_r);
          head_nxt  = head_wrap;
          count_nxt = count_r - CNT_W'(1);
          idx_nxt   = '0;
          len_nxt   = l_rdata;
          state_nxt = pfd_pkg::BK_STREAM;
        end
      end

      pfd_pkg::BK_STREAM: begin
        // The RAM output holds byte idx_r until it is moved to the output.
        if (space) begin
          emit = 1'b1;
          out_data_nxt.out_byte      = b_rdata;
          out_data_nxt.byte_valid    = 1'b1;
          out_data_nxt.popped_length = 7'(len_r);
          out_data_nxt.last          = (idx_inc == len_r);
          if (idx_inc == len_r) begin
            state_nxt = pfd_pkg::BK_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            baddr_nxt = baddr_r + ADDR_W'(1);
            b_re      = 1'b1;
            b_raddr   = baddr_r + ADDR_W'(1);
          end
        end
      end

      default: state_nxt = pfd_pkg::BK_IDLE;
    endcase

    out_data_nxt.stored_packets = 4'(count_nxt);
    out_data_nxt.overflow_count = drop_nxt;

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfd_pkg::BK_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      drop_r      <= '0;
      push_open_r <= 1'b0;
      wpos_r      <= '0;
      exp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      push_open_r <= push_open_nxt;
      wpos_r      <= wpos_nxt;
      exp_r       <= exp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cap_r   <= cap_nxt;
    len_r   <= len_nxt;
    idx_r   <= idx_nxt;
    baddr_r <= baddr_nxt;
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/packet_fifo_drop_newest.sv */
// ----------------------------------------------------------------------------
// packet_fifo_drop_newest: ring FIFO of whole packets
// Accepts init, push header, push data and pop commands; drops new packets
// when the ring is full and streams popped packets byte by byte.
// ----------------------------------------------------------------------------
// Usage: commands arrive as in_data beats on the in_ channel (valid/stall);
// results leave as out_data beats on the out_ channel. Every command gives
// one result, except a data beat with no push open (none) and a successful
// pop (one beat per packet byte, last set on the final byte).
// Path: a result passes through the command queue and then the output
// register; the first byte of a pop also waits while the packet length and
// then the first byte are read from registered RAM ports.
// Throughput: while the receiver does not stall, init, header and data
// commands run at one per cycle, set by the back end, which carries out one
// command per cycle. A successful pop holds the back end for its length read
// and then its bytes, one byte per cycle from the read port when not stalled.
// Reset clears the ring pointers, packet count, drop count and any open
// push; stored bytes are not cleared, and only committed slots are read.
// When the receiver stalls, the output register holds its beat, the back end
// waits, and once the two-entry command queue is full in_stall rises.
// ----------------------------------------------------------------------------
module packet_fifo_drop_newest #(
  parameter int QUEUE_DEPTH      = 8,
  parameter int MAX_PACKET_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfd_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pfd_pkg::result_t  out_data
);

  pfd_pkg::op_item_t front_op;
  pfd_pkg::op_item_t q_data;
  logic              q_valid;
  logic              q_pop;

  pfd_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
    .item   (in_data),
    .op_item(front_op)
  );

  pfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(in_valid),
    .push_stall(in_stall),
    .push_data (front_op),
    .pop_valid (q_valid),
    .pop_ready (q_pop),
    .pop_data  (q_data)
  );

  pfd_back #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Only packet bytes can be followed by further beats of the same command.
  a_nonbyte_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.last)
    else $error("non-byte result without last");

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_valid |->
      out_data.status == pfd_pkg::ST_OK && out_data.popped_length != 7'd0)
    else $error("popped byte with bad status or zero length");

  a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.byte_valid && !out_data.last
      |=> out_valid || q_valid)
    else $error("packet stream ended before its last byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

/* dv/packet_fifo_drop_newest_tb.sv */
// ----------------------------------------------------------------------------
// packet_fifo_drop_newest_tb: self-checking bench for the packet ring FIFO
// Drives init, header, data and pop commands, predicts every result beat with
// a cycle-free model of the ring, and compares each beat field by field; in
// all but the last test both channels may idle in random bursts.
// ----------------------------------------------------------------------------
module packet_fifo_drop_newest_tb;

  localparam int DEPTH        = 8;
  localparam int MAXB         = 64;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_LIMIT = 100;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  pfd_pkg::in_item_t in_data;
  logic              out_valid;
  logic              out_stall;
  pfd_pkg::result_t  out_data;

  packet_fifo_drop_newest #(
    .QUEUE_DEPTH      (DEPTH),
    .MAX_PACKET_BYTES (MAXB)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the ring.
  logic [7:0]  ring_bytes [DEPTH*MAXB];
  logic [6:0]  ring_len [DEPTH];
  logic [2:0]  m_head = '0;
  logic [3:0]  m_count = '0;
  logic [15:0] m_drops = '0;
  logic        m_open = 1'b0;
  logic [6:0]  m_wpos = '0;
  logic [6:0]  m_explen = '0;

  pfd_pkg::result_t pending_results[$];

  bit allow_idle = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  int failures = 0;
  int commands_sent = 0;
  int items_with_results = 0;
  int beats_checked = 0;
  int bytes_popped = 0;
  int peak_drops = 0;

  function automatic pfd_pkg::result_t make_result(pfd_pkg::status_t st, logic [7:0] b,
                                                   logic bv, logic [6:0] plen, logic fin);
    pfd_pkg::result_t r;
    r.status         = st;
    r.out_byte       = b;
    r.byte_valid     = bv;
    r.popped_length  = plen;
    r.last           = fin;
    r.stored_packets = m_count;
    r.overflow_count = m_drops;
    return r;
  endfunction

  function automatic void model_command(pfd_pkg::in_item_t item);
    int slot;
    int plen;
    int prior_size;
    prior_size = pending_results.size();
    case (item.cmd)
      pfd_pkg::CMD_INIT: begin
        m_head   = '0;
        m_count  = '0;
        m_drops  = '0;
        m_open   = 1'b0;
        m_wpos   = '0;
        m_explen = '0;
        pending_results.push_back(make_result(pfd_pkg::ST_OK, 8'h00, 1'b0, 7'd0, 1'b1));
      end
      pfd_pkg::CMD_HEADER: begin
        // A new header always abandons a push that is still open.
        m_open   = 1'b0;
        m_wpos   = '0;
        m_explen = '0;
        if (item.packet_length == 0 || item.packet_length > MAXB) begin
          pending_results.push_back(
            make_result(pfd_pkg::ST_BAD_LENGTH, 8'h00, 1'b0, 7'd0, 1'b1));
        end else if (m_count >= DEPTH) begin
          if (m_drops != pfd_pkg::DROP_MAX) m_drops++;
          pending_results.push_back(
            make_result(pfd_pkg::ST_QUEUE_FULL, 8'h00, 1'b0, 7'd0, 1'b1));
        end else begin
          m_open   = 1'b1;
          m_explen = item.packet_length;
          pending_results.push_back(make_result(pfd_pkg::ST_OK, 8'h00, 1'b0, 7'd0, 1'b1));
        end
      end
      pfd_pkg::CMD_DATA: begin
        if (m_open) begin
          slot = (m_head + m_count) % DEPTH;
          ring_bytes[slot*MAXB + m_wpos] = item.data_byte;
          m_wpos++;
          if (m_wpos >= m_explen) begin
            ring_len[slot] = m_explen;
            m_count++;
            m_open   = 1'b0;
            m_wpos   = '0;
            m_explen = '0;
          end
          pending_results.push_back(make_result(pfd_pkg::ST_OK, 8'h00, 1'b0, 7'd0, 1'b1));
        end
      end
      default: begin
        if (m_count == 0) begin
          pending_results.push_back(
            make_result(pfd_pkg::ST_QUEUE_EMPTY, 8'h00, 1'b0, 7'd0, 1'b1));
        end else begin
          slot = m_head;
          plen = ring_len[slot];
          if (item.capacity < plen) begin
            pending_results.push_back(
              make_result(pfd_pkg::ST_TOO_SMALL, 8'h00, 1'b0, 7'd0, 1'b1));
          end else begin
            m_head = 3'((slot + 1) % DEPTH);
            m_count--;
            for (int i = 0; i < plen; i++) begin
              pending_results.push_back(
                make_result(pfd_pkg::ST_OK, ring_bytes[slot*MAXB + i], 1'b1,
                            7'(plen), (i + 1 == plen)));
            end
          end
        end
      end
    endcase
    if (pending_results.size() != prior_size) items_with_results++;
    if (m_drops > peak_drops) peak_drops = m_drops;
  endfunction

  function automatic pfd_pkg::in_item_t make_item(logic [1:0] cmd, int len, int b, int cap);
    pfd_pkg::in_item_t it;
    it.cmd           = cmd;
    it.packet_length = 7'(len);
    it.data_byte     = 8'(b);
    it.capacity      = 7'(cap);
    return it;
  endfunction

  // One input beat; the payload holds until the beat is taken.
  task automatic send_item(input pfd_pkg::in_item_t item);
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    commands_sent++;
    model_command(item);
  endtask

  task automatic do_init();
    send_item(make_item(pfd_pkg::CMD_INIT, $urandom, $urandom, $urandom));
  endtask

  task automatic do_header(input int len);
    send_item(make_item(pfd_pkg::CMD_HEADER, len, $urandom, $urandom));
  endtask

  task automatic do_byte(input int b);
    send_item(make_item(pfd_pkg::CMD_DATA, $urandom, b, $urandom));
  endtask

  task automatic do_pop(input int cap);
    send_item(make_item(pfd_pkg::CMD_POP, $urandom, $urandom, cap));
  endtask

  task automatic send_packet(input int len);
    do_header(len);
    repeat (len) do_byte($urandom_range(0, 255));
  endtask

  always @(posedge clk) begin
    if (!allow_idle) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // Output values are sampled before the edge updates them.
  always @(posedge clk) begin : check_beats
    pfd_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_checked++;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: unexpected result beat, expected none, actual 0x%0h",
                   $time, out_data);
      end else begin
        want = pending_results.pop_front();
        if (want.byte_valid) bytes_popped++;
        check_field("status", 16'(want.status), 16'(out_data.status));
        check_field("out_byte", 16'(want.out_byte), 16'(out_data.out_byte));
        check_field("byte_valid", 16'(want.byte_valid), 16'(out_data.byte_valid));
        check_field("popped_length", 16'(want.popped_length), 16'(out_data.popped_length));
        check_field("last", 16'(want.last), 16'(out_data.last));
        check_field("stored_packets", 16'(want.stored_packets),
                    16'(out_data.stored_packets));
        check_field("overflow_count", want.overflow_count, out_data.overflow_count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("packet_fifo_drop_newest_tb failed");
      $finish;
    end
  end

  // Error statuses, ignored bytes, aborted and interrupted pushes.
  task automatic test_directed_cases();
    allow_idle = 1'b1;
    do_init();
    do_pop(0);
    do_byte(8'hA5);
    do_header(0);
    do_header(MAXB + 1);
    do_header(127);
    do_header(1);
    do_byte(8'hFF);
    do_pop(0);
    do_pop(127);
    // Pop while a push is open, then finish the push.
    do_header(3);
    do_byte(8'h00);
    do_pop(MAXB);
    do_byte(8'h80);
    do_byte(8'h7F);
    // A second header abandons the first push.
    do_header(2);
    do_byte(8'h11);
    do_header(2);
    do_byte(8'h22);
    do_byte(8'h33);
    do_pop(2);
    do_pop(3);
    do_pop(2);
    // Init abandons an open push; the following byte is dropped silently.
    do_header(4);
    do_byte(8'h01);
    do_init();
    do_byte(8'h02);
    do_pop(127);
  endtask

  task automatic test_long_packets();
    allow_idle = 1'b1;
    do_header(MAXB);
    for (int i = 0; i < MAXB; i++) do_byte((i * 4) ^ (i[0] ? 8'hFF : 8'h00));
    do_pop(MAXB - 1);
    do_pop(MAXB);
    do_pop(127);
  endtask

  // Fill the ring, then push a few more headers that are dropped.
  task automatic test_full_queue();
    allow_idle = 1'b1;
    do_init();
    repeat (DEPTH) send_packet($urandom_range(1, 3));
    do_header(5);
    do_byte(8'h5A);
    do_pop(127);
    send_packet(2);
    do_header(1);
    do_header(0);
    repeat (4) do_header($urandom_range(1, MAXB));
    do_header(MAXB);
    do_header(0);
    do_init();
    do_pop(127);
  endtask

  task automatic run_traffic(input int n_items, input bit with_idle);
    int start;
    int pick;
    int len;
    int cut;
    start = items_with_results;
    allow_idle = with_idle;
    while (items_with_results - start < n_items) begin
      if (with_idle && $urandom_range(0, 39) == 0) allow_idle = !allow_idle;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(1, MAXB) : $urandom_range(1, 6);
        send_packet(len);
      end else if (pick < 78) begin
        // Aim at the head packet's length now and then to hit exact fits.
        if (m_count != 0 && $urandom_range(0, 3) == 0)
          do_pop(int'(ring_len[m_head]) - $urandom_range(0, 1));
        else if ($urandom_range(0, 2) == 0)
          do_pop($urandom_range(0, 127));
        else
          do_pop($urandom_range(MAXB, 127));
      end else if (pick < 84) begin
        do_byte($urandom_range(0, 255));
      end else if (pick < 90) begin
        do_header($urandom_range(0, 1) ? 0 : $urandom_range(MAXB + 1, 127));
      end else if (pick < 97) begin
        len = $urandom_range(2, 8);
        cut = $urandom_range(1, len - 1);
        do_header(len);
        repeat (cut) do_byte($urandom_range(0, 255));
        case ($urandom_range(0, 2))
          0: begin
            do_pop($urandom_range(0, 127));
            repeat (len - cut) do_byte($urandom_range(0, 255));
          end
          1: send_packet($urandom_range(1, 6));
          default: do_init();
        endcase
      end else begin
        do_init();
      end
    end
  endtask

  task automatic test_random_traffic();
    run_traffic(60, 1'b1);
  endtask

  task automatic test_quiet_tail();
    run_traffic(20, 1'b0);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_long_packets();
    test_full_queue();
    test_random_traffic();
    test_quiet_tail();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d commands, %0d of them with results; checked %0d result beats.",
             commands_sent, items_with_results, beats_checked);
    $display("Popped %0d packet bytes; the drop counter peaked at %0d.",
             bytes_popped, peak_drops);
    if (failures == 0) begin
      $display("packet_fifo_drop_newest_tb passed");
    end else begin
      $display("packet_fifo_drop_newest_tb failed");
    end
    $finish;
  end

endmodule
